// File: design/sqlp_pkg.sv
// Shared types and constants for the signal-quality line parser.
// No dependencies; every other design file imports this package.
package sqlp_pkg;

    // One input transfer: a character of the response line or the terminator.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } t_in_item;

    // One result transfer, produced at each terminator.
    typedef struct packed {
        logic       parse_ok;
        logic [6:0] signal_quality;
        logic [6:0] error_rate;
    } t_out_item;

    // Parse phase codes.
    localparam logic [3:0] PH_SEEK_COLON = 4'd0;
    localparam logic [3:0] PH_PRE_Q      = 4'd1;
    localparam logic [3:0] PH_Q_DIGITS   = 4'd2;
    localparam logic [3:0] PH_Q_POST     = 4'd3;
    localparam logic [3:0] PH_PRE_R      = 4'd4;
    localparam logic [3:0] PH_R_DIGITS   = 4'd5;
    localparam logic [3:0] PH_TRAIL      = 4'd6;

    // Line state carried from one character to the next.
    typedef struct packed {
        logic [3:0] parse_phase;
        logic [6:0] quality_accum;
        logic [6:0] rate_accum;
        logic       failed_flag;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        parse_phase:   PH_SEEK_COLON,
        quality_accum: 7'd0,
        rate_accum:    7'd0,
        failed_flag:   1'b0
    };

endpackage

// File: design/sqlp_step.sv
// Combinational next-state and result logic for one character of a line.
// Depends on sqlp_pkg.
module sqlp_step (
    input  sqlp_pkg::t_parse_state i_state,
    input  sqlp_pkg::t_in_item     i_item,
    output sqlp_pkg::t_parse_state o_next_state,
    output logic                   o_res_valid,
    output sqlp_pkg::t_out_item    o_res_item
);
    import sqlp_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [6:0]  VAL_UNKNOWN = 7'd99;
    localparam logic [6:0]  VAL_Q_MAX   = 7'd31;
    localparam logic [6:0]  VAL_R_MAX   = 7'd7;
    localparam logic [10:0] VAL_LIMIT   = 11'd99;

    logic        eol;
    logic        is_blank;
    logic        is_digit;
    logic        is_eol_ws;
    logic        rate_side;
    logic [6:0]  acc_sel;
    logic [10:0] acc_sum;
    logic        acc_ovf;
    logic [6:0]  acc_new;
    logic        ok;

    assign eol       = i_item.end_of_line || (i_item.char_code == CH_NUL);
    assign is_blank  = (i_item.char_code == CH_SPACE) || (i_item.char_code == CH_TAB);
    assign is_digit  = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign is_eol_ws = is_blank || (i_item.char_code == CH_CR) ||
                       (i_item.char_code == CH_LF);

    // One shared digit accumulator: acc * 10 + digit, held when above 99.
    assign rate_side = (i_state.parse_phase == PH_PRE_R) ||
                       (i_state.parse_phase == PH_R_DIGITS);
    assign acc_sel   = rate_side ? i_state.rate_accum : i_state.quality_accum;
    assign acc_sum   = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} +
                       {7'd0, i_item.char_code[3:0]};
    assign acc_ovf   = acc_sum > VAL_LIMIT;
    assign acc_new   = acc_ovf ? acc_sel : acc_sum[6:0];

    always_comb begin
        ok = !i_state.failed_flag &&
             ((i_state.parse_phase == PH_R_DIGITS) || (i_state.parse_phase == PH_TRAIL));
        if ((i_state.quality_accum > VAL_Q_MAX) && (i_state.quality_accum != VAL_UNKNOWN)) begin
            ok = 1'b0;
        end
        if ((i_state.rate_accum > VAL_R_MAX) && (i_state.rate_accum != VAL_UNKNOWN)) begin
            ok = 1'b0;
        end
    end

    assign o_res_valid               = eol;
    assign o_res_item.parse_ok       = ok;
    assign o_res_item.signal_quality = ok ? i_state.quality_accum : 7'd0;
    assign o_res_item.error_rate     = ok ? i_state.rate_accum : 7'd0;

    always_comb begin
        o_next_state = i_state;
        if (eol) begin
            o_next_state = STATE_RESET;
        end else if (!i_state.failed_flag) begin
            unique case (i_state.parse_phase)
                PH_SEEK_COLON: begin
                    if (i_item.char_code == CH_COLON) begin
                        o_next_state.parse_phase = PH_PRE_Q;
                    end
                end
                PH_PRE_Q: begin
                    if (is_digit) begin
                        o_next_state.quality_accum = acc_new;
                        o_next_state.failed_flag   = acc_ovf;
                        o_next_state.parse_phase   = PH_Q_DIGITS;
                    end else if (!is_blank) begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                PH_Q_DIGITS: begin
                    if (is_digit) begin
                        o_next_state.quality_accum = acc_new;
                        o_next_state.failed_flag   = acc_ovf;
                    end else if (is_blank) begin
                        o_next_state.parse_phase = PH_Q_POST;
                    end else if (i_item.char_code == CH_COMMA) begin
                        o_next_state.parse_phase = PH_PRE_R;
                    end else begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                PH_Q_POST: begin
                    if (i_item.char_code == CH_COMMA) begin
                        o_next_state.parse_phase = PH_PRE_R;
                    end else if (!is_blank) begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                PH_PRE_R: begin
                    if (is_digit) begin
                        o_next_state.rate_accum  = acc_new;
                        o_next_state.failed_flag = acc_ovf;
                        o_next_state.parse_phase = PH_R_DIGITS;
                    end else if (!is_blank) begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                PH_R_DIGITS: begin
                    if (is_digit) begin
                        o_next_state.rate_accum  = acc_new;
                        o_next_state.failed_flag = acc_ovf;
                    end else if (is_eol_ws) begin
                        o_next_state.parse_phase = PH_TRAIL;
                    end else begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_eol_ws) begin
                        o_next_state.failed_flag = 1'b1;
                    end
                end
                default: begin
                    o_next_state.failed_flag = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: design/signal_quality_line_parser_top.sv
// Top level of the signal-quality line parser: input register, line state and result register.
// Depends on sqlp_pkg and sqlp_step.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+---------------------------------------
//  input   | i_in_valid | o_in_stall  | i_in_item  (char_code, end_of_line)
//  result  | o_out_valid| i_out_stall | o_out_item (parse_ok, quality, rate)
//
// One character per cycle unless a terminator waits on a held result: a transfer
// lands in the input register, and the step logic then folds it into the line
// state; a terminator also loads the result register. Reset (i_rst_n low,
// synchronous) empties both registers and returns the line state to the
// seek-colon phase. A held result stalls only terminators; ordinary characters
// keep flowing past it.
module signal_quality_line_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sqlp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sqlp_pkg::t_out_item o_out_item
);
    import sqlp_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in_item;
    t_parse_state r_state;
    logic         r_out_valid;
    t_out_item    r_out_item;

    t_parse_state n_state;
    logic         res_valid;
    t_out_item    res_item;
    logic         out_free;
    logic         step_go;
    logic         in_take;

    sqlp_step u_step (
        .i_state      (r_state),
        .i_item       (r_in_item),
        .o_next_state (n_state),
        .o_res_valid  (res_valid),
        .o_res_item   (res_item)
    );

    // The result slot frees when empty or when its transfer completes this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // Advance the held character unless it is a terminator and the slot is busy.
    assign step_go  = r_in_valid && (!res_valid || out_free);
    // Hold the input only while the input register cannot advance.
    assign o_in_stall = r_in_valid && !step_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Update the line state once per consumed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Load a result on a terminator; drop it once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && res_valid) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for signal_quality_line_parser_top.
// Depends on sqlp_pkg and the parser RTL. Streams response lines through the block and
// checks each result against an in-bench parser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sqlp_pkg::*;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int UNKNOWN_VAL  = 99;
    localparam int QUALITY_TOP  = 31;
    localparam int RATE_TOP     = 7;
    localparam int RADIX        = 10;

    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE       = 10;       // margin for stray results after the stream drains
    localparam int CYCLE_LIMIT  = 400000;

    // One queued input transfer; hold_first makes the sender wait for all results first.
    typedef struct packed {
        t_in_item item;
        logic     hold_first;
    } t_pending;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_item;

    t_pending    line_q[$];         // characters still to send
    t_out_item   report_q[$];       // parse results owed by the block
    logic [7:0]  draft[$];          // line under construction
    logic        hold_next = 1'b0;
    t_parse_state line_st;          // in-bench copy of the line state
    t_out_item   predicted;
    t_out_item   want;
    logic [31:0] cycles = '0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          fail_count = 0;

    // Alternate stretches: sender quiet, receiver quiet, both idling, both quiet.
    wire sender_quiet = (cycles[9:8] == 2'd0) || (cycles[9:8] == 2'd3);
    wire recv_quiet   = (cycles[9:8] == 2'd1) || (cycles[9:8] == 2'd3);

    signal_quality_line_parser_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- parser model

    function automatic bit is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB);
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic bit is_trailer(input logic [7:0] ch);
        return is_blank(ch) || (ch == CH_CR) || (ch == CH_LF);
    endfunction

    // Append one decimal digit; anything past 99 latches the failure and keeps the old value.
    function automatic logic [6:0] fold_digit(input logic [6:0] acc, input logic [7:0] ch);
        int sum;
        sum = int'(acc) * RADIX + int'(ch) - int'(CH_ZERO);
        if (sum > UNKNOWN_VAL) begin
            line_st.failed_flag = 1'b1;
            return acc;
        end
        return sum[6:0];
    endfunction

    // Advance the line state by one transfer; return 1 when a terminator produces a result.
    function automatic bit parse_char(input t_in_item it, output t_out_item res);
        logic [7:0] ch;
        bit         ok;
        ch  = it.char_code;
        res = '0;
        if (it.end_of_line || ch == CH_NUL) begin
            ok = !line_st.failed_flag &&
                 (line_st.parse_phase == PH_R_DIGITS || line_st.parse_phase == PH_TRAIL);
            if (line_st.quality_accum > QUALITY_TOP && line_st.quality_accum != UNKNOWN_VAL)
                ok = 1'b0;
            if (line_st.rate_accum > RATE_TOP && line_st.rate_accum != UNKNOWN_VAL)
                ok = 1'b0;
            if (ok) begin
                res.parse_ok       = 1'b1;
                res.signal_quality = line_st.quality_accum;
                res.error_rate     = line_st.rate_accum;
            end
            line_st = STATE_RESET;
            return 1'b1;
        end
        if (line_st.failed_flag)
            return 1'b0;
        case (line_st.parse_phase)
            PH_SEEK_COLON: begin
                if (ch == CH_COLON) line_st.parse_phase = PH_PRE_Q;
            end
            PH_PRE_Q: begin
                if (is_digit(ch)) begin
                    line_st.quality_accum = fold_digit(line_st.quality_accum, ch);
                    line_st.parse_phase   = PH_Q_DIGITS;
                end else if (!is_blank(ch)) begin
                    line_st.failed_flag = 1'b1;
                end
            end
            PH_Q_DIGITS: begin
                if (is_digit(ch)) line_st.quality_accum = fold_digit(line_st.quality_accum, ch);
                else if (is_blank(ch)) line_st.parse_phase = PH_Q_POST;
                else if (ch == CH_COMMA) line_st.parse_phase = PH_PRE_R;
                else line_st.failed_flag = 1'b1;
            end
            PH_Q_POST: begin
                if (ch == CH_COMMA) line_st.parse_phase = PH_PRE_R;
                else if (!is_blank(ch)) line_st.failed_flag = 1'b1;
            end
            PH_PRE_R: begin
                if (is_digit(ch)) begin
                    line_st.rate_accum  = fold_digit(line_st.rate_accum, ch);
                    line_st.parse_phase = PH_R_DIGITS;
                end else if (!is_blank(ch)) begin
                    line_st.failed_flag = 1'b1;
                end
            end
            PH_R_DIGITS: begin
                if (is_digit(ch)) line_st.rate_accum = fold_digit(line_st.rate_accum, ch);
                else if (is_trailer(ch)) line_st.parse_phase = PH_TRAIL;
                else line_st.failed_flag = 1'b1;
            end
            PH_TRAIL: begin
                if (!is_trailer(ch)) line_st.failed_flag = 1'b1;
            end
            default: line_st.failed_flag = 1'b1;
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- line builders

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic push_item(input logic [7:0] ch, input logic eol);
        t_pending p;
        p.item.char_code   = ch;
        p.item.end_of_line = eol;
        p.hold_first       = hold_next;
        hold_next          = 1'b0;
        line_q.push_back(p);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endtask

    task automatic add_blanks(input int most);
        repeat ($urandom_range(0, most)) draft.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // Decimal digits, sometimes with leading zeros
    task automatic add_number(input int v);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) draft.push_back(CH_ZERO);
        add_text($sformatf("%0d", v));
    endtask

    // Mostly legal values, with the unknown code, the gap below 99 and overflow mixed in
    function automatic int pick_value(input int top);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, top);
            6:                return UNKNOWN_VAL;
            7:                return $urandom_range(top + 1, UNKNOWN_VAL - 1);
            8:                return $urandom_range(UNKNOWN_VAL + 1, 999);
            default:          return $urandom_range(0, 1) ? top : 0;
        endcase
    endfunction

    // Well-formed report with random prefix, spacing and trailer
    task automatic add_report(input int q, input int r);
        case ($urandom_range(0, 3))
            0: ;
            1, 3: add_text("+CSQ");
            default: repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(8'h41, 8'h5A)));
        endcase
        draft.push_back(CH_COLON);
        add_blanks(2);
        add_number(q);
        if ($urandom_range(0, 3) == 0) add_blanks(2);
        draft.push_back(CH_COMMA);
        add_blanks(1);
        add_number(r);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0: draft.push_back(CH_SPACE);
                1: draft.push_back(CH_TAB);
                2: draft.push_back(CH_CR);
                default: draft.push_back(CH_LF);
            endcase
        end
    endtask

    // Flush the draft, then close the line with a flagged or a NUL terminator
    task automatic send_draft();
        int i;
        for (i = 0; i < draft.size(); i++) push_item(draft[i], 1'b0);
        draft.delete();
        if ($urandom_range(0, 1)) push_item(8'($urandom_range(0, 255)), 1'b1);
        else push_item(CH_NUL, 1'b0);
    endtask

    // ---------------------------------------------------------------- driver

    // Predict at the transfer edge, then advance to the next queued character after its gap.
    // A character marked hold_first stays back until every owed result has been taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            line_st  = STATE_RESET;
        end else begin
            if (in_valid && !in_stall) begin
                if (parse_char(in_item, predicted)) report_q.push_back(predicted);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (line_q.size() != 0 &&
                             !(line_q[0].hold_first && report_q.size() != 0)) begin
                    in_item  <= line_q[0].item;
                    in_valid <= 1'b1;
                    gap_left <= draw_wait(sender_quiet);
                    line_q.delete(0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Check each result transfer against the oldest owed result, then stall for a while.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (report_q.size() == 0) begin
                    $error("result transfer with no terminator outstanding");
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (out_item.parse_ok !== want.parse_ok) begin
                        $error("parse_ok: expected %0d, actual %0d",
                               want.parse_ok, out_item.parse_ok);
                        fail_count++;
                    end
                    if (out_item.signal_quality !== want.signal_quality) begin
                        $error("signal_quality: expected %0d, actual %0d",
                               want.signal_quality, out_item.signal_quality);
                        fail_count++;
                    end
                    if (out_item.error_rate !== want.error_rate) begin
                        $error("error_rate: expected %0d, actual %0d",
                               want.error_rate, out_item.error_rate);
                        fail_count++;
                    end
                end
                stall_left = draw_wait(recv_quiet);
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: abort if the stream never drains
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus and end

    initial begin : main
        int fed;
        int lines;
        int kind;
        fed   = 0;
        lines = 0;

        // Directed: smallest values with a flagged terminator over an all-ones code
        add_text(":0,0");
        for (int i = 0; i < draft.size(); i++) push_item(draft[i], 1'b0);
        draft.delete();
        push_item(8'hFF, 1'b1);
        // unknown codes, tab before the comma, LF trailer, NUL terminator
        add_text(":99");
        draft.push_back(CH_TAB);
        add_text(",99");
        draft.push_back(CH_LF);
        for (int i = 0; i < draft.size(); i++) push_item(draft[i], 1'b0);
        draft.delete();
        push_item(CH_NUL, 1'b0);
        // in range of two digits but outside the allowed set
        add_text(":32,8");
        for (int i = 0; i < draft.size(); i++) push_item(draft[i], 1'b0);
        draft.delete();
        push_item(CH_NUL, 1'b1);
        // overflow past 99, then a line with no colon at all
        add_text(":100");
        for (int i = 0; i < draft.size(); i++) push_item(draft[i], 1'b0);
        draft.delete();
        push_item(8'h00, 1'b1);
        push_item(CH_COMMA, 1'b0);
        push_item(8'h7F, 1'b1);

        // Random: mostly reports, some corrupted, truncated or missing a character, some noise
        while (fed < RANDOM_ITEMS) begin
            if (lines == 30 || $urandom_range(0, 24) == 0) hold_next = 1'b1;
            kind = $urandom_range(0, 19);
            if (kind < 18) begin
                add_report(pick_value(QUALITY_TOP), pick_value(RATE_TOP));
                if (kind == 13 || kind == 14)
                    draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
                else if (kind == 15)
                    repeat ($urandom_range(1, draft.size() - 1)) draft.delete(draft.size() - 1);
                else if (kind == 16)
                    draft.delete($urandom_range(0, draft.size() - 1));
            end else begin
                repeat ($urandom_range(0, 12)) draft.push_back(8'($urandom_range(0, 255)));
            end
            fed += draft.size() + 1;
            send_draft();
            lines++;
        end

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain everything, then give the pipeline time to show any stray result
        while (line_q.size() != 0 || in_valid) @(posedge clk);
        while (report_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/sqlp_pkg.sv
design/sqlp_step.sv
design/signal_quality_line_parser_top.sv
tb/sv/testbench.sv
